// ----- rtl/core/mbu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI-to-USB event packet package
// Shared constants, status byte codes, code index numbers, the queue entry
// type and the message length and code index classifier.
// ----------------------------------------------------------------------------
package mbu_pkg;

  // Number of virtual cables that keep parse state.
  localparam int CABLES = 4;
  localparam int CIDX_W = (CABLES > 1) ? $clog2(CABLES) : 1;

  // Depth of the queue between the front and the back (power of two, >= 2).
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Status bytes with special meaning.
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_REALTIME    = 8'hF8;
  localparam logic [7:0] ST_SYSTEM      = 8'hF0;

  // Code index numbers.
  localparam logic [3:0] CIN_SYS_TWO   = 4'h2;
  localparam logic [3:0] CIN_SYS_THREE = 4'h3;
  localparam logic [3:0] CIN_SYSEX     = 4'h4;
  localparam logic [3:0] CIN_SINGLE    = 4'h5;

  // Message lengths.
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // Status high nibbles: two-byte voice messages, and the system range.
  localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
  localparam logic [3:0] HI_SYSTEM      = 4'hF;

  typedef struct packed {
    logic [1:0] len;
    logic [3:0] code;
  } cls_t;

  // One decoded byte as it travels from the front to the back.
  typedef struct packed {
    logic [CIDX_W-1:0] cable;
    logic [7:0]        data;
    logic              is_data;
    logic              is_f0;
    logic              is_f7;
    logic              is_rt;
    logic              is_voice;
    cls_t              cls;
  } dec_t;

  // Message length and code index number of a status byte.
  function automatic cls_t classify(input logic [7:0] st);
    cls_t r;
    r.len  = LEN_ONE;
    r.code = CIN_SINGLE;
    if (st[7] && st[7:4] != HI_SYSTEM) begin
      r.len  = (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS) ? LEN_TWO : LEN_THREE;
      r.code = st[7:4];
    end else if (st[7]) begin
      case (st)
        ST_SYSEX_START: begin r.len = LEN_THREE; r.code = CIN_SYSEX;     end
        ST_MTC_QFRAME:  begin r.len = LEN_TWO;   r.code = CIN_SYS_TWO;   end
        ST_SONG_POS:    begin r.len = LEN_THREE; r.code = CIN_SYS_THREE; end
        ST_SONG_SEL:    begin r.len = LEN_TWO;   r.code = CIN_SYS_TWO;   end
        default:        begin r.len = LEN_ONE;   r.code = CIN_SINGLE;    end
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/midi_byte_to_usb_event_packet_core.sv -----
`timescale 1ns / 1ps
// out_valid rises once the input transfer that completes an event has passed
// the queue write and then the packet register, if the queue ahead is empty.
// Throughput: one byte per cycle; in_ready drops only while the two-entry queue
// is full, which happens once the output register has stalled.
// Reset: synchronous, active low; clears all per-cable state, the queue and
// the output valid flag. No clearing pass is needed.
// ----------------------------------------------------------------------------
// MIDI-to-USB event packet encoder
// Turns a stream of raw MIDI bytes, each tagged with a virtual cable, into
// four-byte USB-MIDI event packets (cable, code index number, three bytes).
// ----------------------------------------------------------------------------
module midi_byte_to_usb_event_packet_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_midi_byte,
  input  logic [3:0] in_cable,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_packet_cable,
  output logic [3:0] out_code_index,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic [7:0] out_third_byte
);

  // The front decodes each byte (kind of byte, message length and code index
  // for a status byte) and drops bytes for cables beyond the configured count.
  // Such a byte is still a completed input transfer; it just never reaches
  // the queue.
  mbu_pkg::dec_t q_in, q_head;
  logic          q_push, q_not_full, q_pop, q_not_empty;

  mbu_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_midi_byte (in_midi_byte),
    .in_cable     (in_cable),
    .q_ready      (q_not_full),
    .q_push       (q_push),
    .q_entry      (q_in)
  );

  // The queue decouples input ready from output ready, so an output stall
  // does not reach the input until the queue has filled.
  mbu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // The back owns all per-cable parse state (running status, byte count,
  // SysEx flag, the saved data byte and the packet under construction) and
  // registers each finished packet for the output transfer.
  mbu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_cable (out_packet_cable),
    .out_code_index   (out_code_index),
    .out_first_byte   (out_first_byte),
    .out_second_byte  (out_second_byte),
    .out_third_byte   (out_third_byte)
  );

endmodule

// ----- rtl/core/mbu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI-to-USB front end
// Accepts input bytes, drops bytes for cables without state and decodes the
// rest into queue entries.
// ----------------------------------------------------------------------------
module mbu_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_midi_byte,
  input  logic [3:0]        in_cable,
  input  logic              q_ready,
  output logic              q_push,
  output mbu_pkg::dec_t     q_entry
);

  logic cable_ok;

  assign in_ready = q_ready;
  assign cable_ok = ({1'b0, in_cable} < 5'(mbu_pkg::CABLES));
  assign q_push   = in_valid && q_ready && cable_ok;

  always_comb begin
    q_entry.cable    = mbu_pkg::CIDX_W'(in_cable);
    q_entry.data     = in_midi_byte;
    q_entry.is_data  = !in_midi_byte[7];
    q_entry.is_f0    = (in_midi_byte == mbu_pkg::ST_SYSEX_START);
    q_entry.is_f7    = (in_midi_byte == mbu_pkg::ST_SYSEX_END);
    q_entry.is_rt    = (in_midi_byte >= mbu_pkg::ST_REALTIME);
    q_entry.is_voice = in_midi_byte[7] && (in_midi_byte < mbu_pkg::ST_SYSTEM);
    q_entry.cls      = mbu_pkg::classify(in_midi_byte);
  end

endmodule

// ----- rtl/core/mbu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI-to-USB decoupling queue
// Small FIFO of decoded bytes between the front and the back.
// ----------------------------------------------------------------------------
module mbu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbu_pkg::dec_t push_entry,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output mbu_pkg::dec_t head
);

  mbu_pkg::dec_t                   mem_r [mbu_pkg::QDEPTH];
  logic [mbu_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mbu_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mbu_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                            do_pop;

  assign not_full  = (count_r != mbu_pkg::QCNT_W'(mbu_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/core/mbu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI-to-USB back end
// Keeps the per-cable parse state, applies one decoded byte per cycle while
// the output is not stalled, and holds the finished event packet in an
// output register.
module mbu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  mbu_pkg::dec_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    out_packet_cable,
  output logic [3:0]    out_code_index,
  output logic [7:0]    out_first_byte,
  output logic [7:0]    out_second_byte,
  output logic [7:0]    out_third_byte
);

  // Per-cable state.
  logic [1:0] pend_r  [mbu_pkg::CABLES];
  logic [1:0] expc_r  [mbu_pkg::CABLES];
  logic       sysex_r [mbu_pkg::CABLES];
  logic [7:0] rstat_r [mbu_pkg::CABLES];
  logic [6:0] sdata_r [mbu_pkg::CABLES];
  logic       svalid_r[mbu_pkg::CABLES];
  logic [3:0] hcode_r [mbu_pkg::CABLES];
  logic [7:0] hb0_r   [mbu_pkg::CABLES];
  logic [7:0] hb1_r   [mbu_pkg::CABLES];
  logic [7:0] hb2_r   [mbu_pkg::CABLES];

  // Next state of the selected cable.
  logic [1:0] pend_nxt, expc_nxt;
  logic       sysex_nxt, svalid_nxt;
  logic [7:0] rstat_nxt;
  logic [6:0] sdata_nxt;
  logic [3:0] hcode_nxt;
  logic [7:0] hb0_nxt, hb1_nxt, hb2_nxt;
  logic       drop, emit;
  logic [1:0] slot, cnt;
  mbu_pkg::cls_t rs_cls;

  logic       out_valid_r, out_valid_nxt;
  logic [3:0] cable_r, code_r;
  logic [7:0] b0_r, b1_r, b2_r;

  logic [mbu_pkg::CIDX_W-1:0] c;
  logic [7:0]                 b;

  assign c     = q_head.cable;
  assign b     = q_head.data;
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    pend_nxt   = pend_r[c];
    expc_nxt   = expc_r[c];
    sysex_nxt  = sysex_r[c];
    rstat_nxt  = rstat_r[c];
    sdata_nxt  = sdata_r[c];
    svalid_nxt = svalid_r[c];
    hcode_nxt  = hcode_r[c];
    hb0_nxt    = hb0_r[c];
    hb1_nxt    = hb1_r[c];
    hb2_nxt    = hb2_r[c];
    drop       = 1'b0;
    rs_cls     = mbu_pkg::classify(rstat_r[c]);

    // A data byte at the start of a message reuses the running status.
    if (pend_nxt == 2'd0 && q_head.is_data && !sysex_nxt) begin
      if (rstat_nxt == 8'h00) begin
        drop = 1'b1;
      end
      expc_nxt  = rs_cls.len;
      hcode_nxt = rs_cls.code;
      hb0_nxt   = rstat_nxt;
      hb1_nxt   = 8'h00;
      hb2_nxt   = 8'h00;
      if (svalid_nxt && rs_cls.len == mbu_pkg::LEN_THREE) begin
        hb1_nxt  = {1'b0, sdata_nxt};
        pend_nxt = 2'd2;
      end else begin
        pend_nxt = 2'd1;
      end
    end

    // A status byte other than F7 abandons a partial message or SysEx.
    if (pend_nxt != 2'd0 && !q_head.is_data && !q_head.is_f7) begin
      pend_nxt  = 2'd0;
      sysex_nxt = 1'b0;
    end

    if (q_head.is_f0) begin
      sysex_nxt = 1'b1;
    end

    if (pend_nxt == 2'd0) begin
      if (q_head.is_voice) begin
        rstat_nxt  = b;
        svalid_nxt = 1'b0;
      end
      hcode_nxt = 4'h0;
      hb0_nxt   = 8'h00;
      hb1_nxt   = 8'h00;
      hb2_nxt   = 8'h00;
      if (!sysex_nxt) begin
        expc_nxt  = q_head.cls.len;
        hcode_nxt = q_head.cls.code;
      end
    end

    if (q_head.is_data) begin
      sdata_nxt  = b[6:0];
      svalid_nxt = 1'b1;
    end

    slot = (pend_nxt == 2'd3) ? 2'd2 : pend_nxt;
    case (slot)
      2'd0:    hb0_nxt = b;
      2'd1:    hb1_nxt = b;
      default: hb2_nxt = b;
    endcase
    cnt      = slot + 2'd1;
    pend_nxt = cnt;

    if (sysex_nxt) begin
      expc_nxt  = mbu_pkg::LEN_THREE;
      hcode_nxt = mbu_pkg::CIN_SYSEX;
      if (q_head.is_f7) begin
        expc_nxt  = cnt;
        hcode_nxt = 4'(cnt) + mbu_pkg::CIN_SYSEX;
        sysex_nxt = 1'b0;
      end
    end

    emit = (cnt >= expc_nxt) && !drop;
    if (cnt >= expc_nxt) begin
      pend_nxt = 2'd0;
      if (!q_head.is_rt) begin
        svalid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mbu_pkg::CABLES; i++) begin
        pend_r[i]   <= '0;
        expc_r[i]   <= '0;
        sysex_r[i]  <= 1'b0;
        rstat_r[i]  <= '0;
        sdata_r[i]  <= '0;
        svalid_r[i] <= 1'b0;
        hcode_r[i]  <= '0;
        hb0_r[i]    <= '0;
        hb1_r[i]    <= '0;
        hb2_r[i]    <= '0;
      end
    end else if (q_pop && !drop) begin
      pend_r[c]   <= pend_nxt;
      expc_r[c]   <= expc_nxt;
      sysex_r[c]  <= sysex_nxt;
      rstat_r[c]  <= rstat_nxt;
      sdata_r[c]  <= sdata_nxt;
      svalid_r[c] <= svalid_nxt;
      hcode_r[c]  <= hcode_nxt;
      hb0_r[c]    <= hb0_nxt;
      hb1_r[c]    <= hb1_nxt;
      hb2_r[c]    <= hb2_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      cable_r <= 4'(c);
      code_r  <= hcode_nxt;
      b0_r    <= hb0_nxt;
      b1_r    <= hb1_nxt;
      b2_r    <= hb2_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_packet_cable = cable_r;
  assign out_code_index   = code_r;
  assign out_first_byte   = b0_r;
  assign out_second_byte  = b1_r;
  assign out_third_byte   = b2_r;

endmodule

// ----- rtl/core/mbu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI-to-USB port checker
// Watches the top-level ports for packet framing and handshake slips.
// ----------------------------------------------------------------------------
module mbu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_packet_cable,
  input logic [3:0] out_code_index,
  input logic [7:0] out_first_byte,
  input logic [7:0] out_second_byte,
  input logic [7:0] out_third_byte
);

  // A stalled packet stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_index)
      && $stable(out_first_byte) && $stable(out_packet_cable))
    else $error("stalled packet changed");

  // No packet comes out right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("packet valid after reset");

  // Only codes the encoder can produce.
  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code_index != 4'h0 && out_code_index != 4'h1
      && out_code_index != 4'hF)
    else $error("illegal code index");

  // Single-byte packets carry zero padding.
  a_single_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_index == mbu_pkg::CIN_SINGLE |->
      out_second_byte == 8'h00 && out_third_byte == 8'h00)
    else $error("single-byte packet not padded");

  // Packets only for cables that keep state.
  a_cable_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_packet_cable} < 5'(mbu_pkg::CABLES))
    else $error("packet for unknown cable");

endmodule

bind midi_byte_to_usb_event_packet_core mbu_checker u_mbu_checker (.*);

// ----- bench/tb_midi_byte_to_usb_event_packet_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the MIDI-to-USB event packet encoder
// Feeds raw MIDI bytes on random cables and checks every event packet against
// an in-bench parser model: a directed table first, then random messages
// under three idling mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_midi_byte_to_usb_event_packet_core;

  // Code index numbers of the voice messages used in the directed table. A
  // voice packet carries the high nibble of its status byte as its code.
  localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
  localparam logic [3:0] CIN_PROG_CHANGE = 4'hC;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 4;
  localparam int PHASE_BYTES  = 400;
  localparam int HOLD_CYCLES  = 300;
  // A packet rises on out_valid after its input transfer has passed the queue
  // and the packet register; allow some slack.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [3:0] cable;
    logic [3:0] cin;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } usb_event_t;

  // How a directed row is checked: by the parser model, by a typed "no
  // packet", or by a typed packet.
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_PACKET} row_check_t;

  typedef struct {
    logic [7:0] midi;
    logic [3:0] cable;
    row_check_t chk;
    usb_event_t pkt;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_midi_byte;
  logic [3:0] in_cable;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] out_packet_cable;
  logic [3:0] out_code_index;
  logic [7:0] out_first_byte;
  logic [7:0] out_second_byte;
  logic [7:0] out_third_byte;

  midi_byte_to_usb_event_packet_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_midi_byte     (in_midi_byte),
    .in_cable         (in_cable),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_cable (out_packet_cable),
    .out_code_index   (out_code_index),
    .out_first_byte   (out_first_byte),
    .out_second_byte  (out_second_byte),
    .out_third_byte   (out_third_byte)
  );

  // Parser model state, one entry per cable, mirroring what the block keeps.
  logic [1:0] fill_cnt     [mbu_pkg::CABLES];
  logic [1:0] want_len     [mbu_pkg::CABLES];
  logic       in_sysex_msg [mbu_pkg::CABLES];
  logic [7:0] run_status   [mbu_pkg::CABLES];
  logic [6:0] last_data    [mbu_pkg::CABLES];
  logic       last_data_ok [mbu_pkg::CABLES];
  logic [3:0] build_cin    [mbu_pkg::CABLES];
  logic [7:0] build_bytes  [mbu_pkg::CABLES][3];

  // Packets the block still owes, oldest first.
  usb_event_t usb_packets_due[$];
  stim_row_t  directed_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int bytes_fed;
  int bytes_ignored;
  int packets_seen;
  int mismatches;
  int cycle_count;
  usb_event_t got_pkt;
  usb_event_t want_pkt;

  // The clock toggles every half period.
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Run limit, sized far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d packets still due", cycle_count,
               usb_packets_due.size());
      $display("tb_midi_byte_to_usb_event_packet_core: errors");
      $finish;
    end
  end

  // Message length and code index number of a status byte. Voice statuses
  // carry their high nibble as code; system common bytes have fixed entries;
  // anything else is a single-byte packet.
  function automatic void msg_shape(input logic [7:0] st, output logic [1:0] len,
                                    output logic [3:0] cin);
    len = mbu_pkg::LEN_ONE;
    cin = mbu_pkg::CIN_SINGLE;
    if (st[7] && st[7:4] != mbu_pkg::HI_SYSTEM) begin
      cin = st[7:4];
      if (st[7:4] == mbu_pkg::HI_PROG_CHANGE || st[7:4] == mbu_pkg::HI_CHAN_PRESS) begin
        len = mbu_pkg::LEN_TWO;
      end else begin
        len = mbu_pkg::LEN_THREE;
      end
    end else if (st == mbu_pkg::ST_SYSEX_START) begin
      len = mbu_pkg::LEN_THREE;
      cin = mbu_pkg::CIN_SYSEX;
    end else if (st == mbu_pkg::ST_MTC_QFRAME || st == mbu_pkg::ST_SONG_SEL) begin
      len = mbu_pkg::LEN_TWO;
      cin = mbu_pkg::CIN_SYS_TWO;
    end else if (st == mbu_pkg::ST_SONG_POS) begin
      len = mbu_pkg::LEN_THREE;
      cin = mbu_pkg::CIN_SYS_THREE;
    end
  endfunction

  // Advances the parser model by one byte. Returns 1 and fills pkt when the
  // byte completes an event packet.
  function automatic bit encode_midi_byte(input logic [7:0] b, input logic [3:0] c,
                                          output usb_event_t pkt);
    int k;
    int cnt;
    logic [1:0] len;
    logic [3:0] cin;
    pkt = '0;
    // Cables beyond the configured count are ignored outright.
    if (c >= mbu_pkg::CABLES) return 1'b0;
    k = c;

    // A data byte at the start of a message reuses the running status. With
    // no running status the byte is dropped and nothing changes.
    if (fill_cnt[k] == 2'd0 && !b[7] && !in_sysex_msg[k]) begin
      if (run_status[k] == 8'h00) return 1'b0;
      msg_shape(run_status[k], len, cin);
      want_len[k] = len;
      build_cin[k] = cin;
      build_bytes[k][0] = run_status[k];
      build_bytes[k][1] = 8'h00;
      build_bytes[k][2] = 8'h00;
      // A data byte cut off by a real-time byte comes back as second byte,
      // but only for three-byte messages.
      if (last_data_ok[k] && len == mbu_pkg::LEN_THREE) begin
        build_bytes[k][1] = {1'b0, last_data[k]};
        fill_cnt[k] = 2'd2;
      end else begin
        fill_cnt[k] = 2'd1;
      end
    end

    // Any status other than end-of-SysEx abandons the partial message.
    if (fill_cnt[k] != 2'd0 && b[7] && b != mbu_pkg::ST_SYSEX_END) begin
      fill_cnt[k] = 2'd0;
      in_sysex_msg[k] = 1'b0;
    end

    if (b == mbu_pkg::ST_SYSEX_START) in_sysex_msg[k] = 1'b1;

    if (fill_cnt[k] == 2'd0) begin
      if (b[7] && b[7:4] != mbu_pkg::HI_SYSTEM) begin
        run_status[k] = b;
        last_data_ok[k] = 1'b0;
      end
      build_cin[k] = 4'h0;
      build_bytes[k][0] = 8'h00;
      build_bytes[k][1] = 8'h00;
      build_bytes[k][2] = 8'h00;
      if (!in_sysex_msg[k]) begin
        msg_shape(b, len, cin);
        want_len[k] = len;
        build_cin[k] = cin;
      end
    end

    if (!b[7]) begin
      last_data[k] = b[6:0];
      last_data_ok[k] = 1'b1;
    end

    cnt = (fill_cnt[k] > 2'd2) ? 2 : int'(fill_cnt[k]);
    build_bytes[k][cnt] = b;
    cnt = cnt + 1;
    fill_cnt[k] = 2'(cnt);

    // SysEx goes out in three-byte chunks; the closing byte sets the code
    // from the number of bytes in the final chunk.
    if (in_sysex_msg[k]) begin
      want_len[k] = mbu_pkg::LEN_THREE;
      build_cin[k] = mbu_pkg::CIN_SYSEX;
      if (b == mbu_pkg::ST_SYSEX_END) begin
        want_len[k] = 2'(cnt);
        build_cin[k] = 4'(cnt) + mbu_pkg::CIN_SYSEX;
        in_sysex_msg[k] = 1'b0;
      end
    end

    if (cnt >= int'(want_len[k])) begin
      fill_cnt[k] = 2'd0;
      // Real-time bytes leave the saved data byte usable for a restore.
      if (b < mbu_pkg::ST_REALTIME) last_data_ok[k] = 1'b0;
      pkt.cable = c;
      pkt.cin = build_cin[k];
      pkt.b0 = build_bytes[k][0];
      pkt.b1 = build_bytes[k][1];
      pkt.b2 = build_bytes[k][2];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic add_row(input logic [7:0] b, input logic [3:0] c, input row_check_t chk,
                         input usb_event_t pkt);
    stim_row_t r;
    r.midi = b;
    r.cable = c;
    r.chk = chk;
    r.pkt = pkt;
    directed_rows.push_back(r);
  endtask

  // Offers one byte and waits for its transfer. Called and returns right
  // after a falling edge, so valid and payload only ever change there.
  task automatic feed_byte(input logic [7:0] b, input logic [3:0] c, input row_check_t chk,
                           input usb_event_t typed_pkt);
    usb_event_t pkt;
    bit has_pkt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_midi_byte <= b;
    in_cable <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The transfer happened at this edge; book what it should produce.
    has_pkt = encode_midi_byte(b, c, pkt);
    case (chk)
      CHK_PREDICT: if (has_pkt) usb_packets_due.push_back(pkt);
      CHK_PACKET:  usb_packets_due.push_back(typed_pkt);
      default:     ;
    endcase
    if (c < mbu_pkg::CABLES) bytes_fed++;
    else bytes_ignored++;
    @(negedge clk);
  endtask

  // Drops valid and waits until every booked packet has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (usb_packets_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_data();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'h7F;
    return 8'($urandom_range(127));
  endfunction

  // Data byte, now and then preceded by a real-time byte that cuts in.
  task automatic feed_data(input logic [3:0] c);
    if ($urandom_range(99) < 8) feed_byte(8'($urandom_range(255, 248)), c, CHK_PREDICT, '0);
    feed_byte(rand_data(), c, CHK_PREDICT, '0);
  endtask

  // One random message: mostly well-formed voice, running-status, SysEx,
  // system common and real-time traffic, with broken messages and noise.
  task automatic play_message();
    logic [3:0] c;
    logic [7:0] st;
    int kind;
    int n;
    c = ($urandom_range(19) == 0) ? 4'($urandom_range(15, mbu_pkg::CABLES)) :
                                     4'($urandom_range(mbu_pkg::CABLES - 1));
    kind = $urandom_range(99);
    if (kind < 35) begin
      st = {4'($urandom_range(14, 8)), 4'($urandom_range(15))};
      n = (st[7:4] == mbu_pkg::HI_PROG_CHANGE || st[7:4] == mbu_pkg::HI_CHAN_PRESS) ? 1 : 2;
      // Some messages are cut short so that the next status abandons them.
      if ($urandom_range(9) == 0) n = n - 1;
      feed_byte(st, c, CHK_PREDICT, '0);
      repeat (n) feed_data(c);
    end else if (kind < 55) begin
      repeat ($urandom_range(4, 1)) feed_data(c);
    end else if (kind < 70) begin
      feed_byte(mbu_pkg::ST_SYSEX_START, c, CHK_PREDICT, '0);
      repeat ($urandom_range(8)) feed_data(c);
      if ($urandom_range(9) != 0) feed_byte(mbu_pkg::ST_SYSEX_END, c, CHK_PREDICT, '0);
      else feed_byte(8'($urandom_range(255, 128)), c, CHK_PREDICT, '0);
    end else if (kind < 80) begin
      st = 8'($urandom_range(246, 241));
      if (st == mbu_pkg::ST_SONG_POS) n = 2;
      else if (st == mbu_pkg::ST_MTC_QFRAME || st == mbu_pkg::ST_SONG_SEL) n = 1;
      else n = 0;
      feed_byte(st, c, CHK_PREDICT, '0);
      repeat (n) feed_data(c);
    end else if (kind < 88) begin
      feed_byte(8'($urandom_range(255, 248)), c, CHK_PREDICT, '0);
    end else begin
      feed_byte(8'($urandom_range(255)), c, CHK_PREDICT, '0);
    end
  endtask

  // Output side: takes a packet at every rising edge where out_valid and
  // out_ready are both high and compares it with the oldest booked packet.
  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %02h, got %02h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_pkt = '{out_packet_cable, out_code_index, out_first_byte, out_second_byte,
                  out_third_byte};
      if (usb_packets_due.size() == 0) begin
        $error("packet with no expectation: %h", got_pkt);
        mismatches++;
      end else begin
        want_pkt = usb_packets_due.pop_front();
        check_field("packet_cable", 8'(want_pkt.cable), 8'(got_pkt.cable));
        check_field("code_index", 8'(want_pkt.cin), 8'(got_pkt.cin));
        check_field("first_byte", want_pkt.b0, got_pkt.b0);
        check_field("second_byte", want_pkt.b1, got_pkt.b1);
        check_field("third_byte", want_pkt.b2, got_pkt.b2);
      end
      packets_seen++;
    end
  end

  // Receiver: random back-pressure at the falling edge. On request it holds
  // out_ready low for a long stretch so that the block backs up and drops
  // in_ready while the sender keeps offering bytes.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int send_pct[3];
    int recv_pct[3];
    int target;
    send_pct = '{28, 63, 0};
    recv_pct = '{63, 28, 0};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_midi_byte = 8'h00;
    in_cable = 4'h0;
    hold_req = 1'b0;
    cycle_count = 0;
    bytes_fed = 0;
    bytes_ignored = 0;
    packets_seen = 0;
    mismatches = 0;
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    for (int k = 0; k < mbu_pkg::CABLES; k++) begin
      fill_cnt[k] = '0;
      want_len[k] = '0;
      in_sysex_msg[k] = 1'b0;
      run_status[k] = '0;
      last_data[k] = '0;
      last_data_ok[k] = 1'b0;
      build_cin[k] = '0;
      for (int j = 0; j < 3; j++) build_bytes[k][j] = '0;
    end

    // Directed table. Right after reset a data byte has no running status
    // and is dropped. A note-on completes, running status resumes, and a
    // real-time byte cuts in; the data byte taken before it is restored in
    // the next note. Other rows cover cables out of range, two-byte voice
    // messages, a SysEx transfer ending on a short final chunk, a lone F7,
    // the system common messages, F7 inside a voice message, and a status
    // byte that abandons a partial message.
    add_row(8'h45, 4'd0, CHK_NONE, '0);
    add_row(8'h90, 4'd0, CHK_PREDICT, '0);
    add_row(8'h3C, 4'd0, CHK_PREDICT, '0);
    add_row(8'h7F, 4'd0, CHK_PACKET, '{4'd0, CIN_NOTE_ON, 8'h90, 8'h3C, 8'h7F});
    add_row(8'h40, 4'd0, CHK_PREDICT, '0);
    add_row(8'hF8, 4'd0, CHK_PACKET, '{4'd0, mbu_pkg::CIN_SINGLE, 8'hF8, 8'h00, 8'h00});
    add_row(8'h41, 4'd0, CHK_PREDICT, '0);
    add_row(8'h90, 4'd4, CHK_NONE, '0);
    add_row(8'hFF, 4'd15, CHK_NONE, '0);
    add_row(8'hC5, 4'd3, CHK_PREDICT, '0);
    add_row(8'h00, 4'd3, CHK_PACKET, '{4'd3, CIN_PROG_CHANGE, 8'hC5, 8'h00, 8'h00});
    add_row(8'h7F, 4'd3, CHK_PREDICT, '0);
    add_row(8'hF0, 4'd1, CHK_PREDICT, '0);
    add_row(8'h01, 4'd1, CHK_PREDICT, '0);
    add_row(8'h02, 4'd1, CHK_PREDICT, '0);
    add_row(8'h03, 4'd1, CHK_PREDICT, '0);
    add_row(8'hF7, 4'd1, CHK_PREDICT, '0);
    add_row(8'hF7, 4'd2, CHK_PACKET, '{4'd2, mbu_pkg::CIN_SINGLE, 8'hF7, 8'h00, 8'h00});
    add_row(8'hF2, 4'd2, CHK_PREDICT, '0);
    add_row(8'h7F, 4'd2, CHK_PREDICT, '0);
    add_row(8'h00, 4'd2, CHK_PREDICT, '0);
    add_row(8'hF1, 4'd2, CHK_PREDICT, '0);
    add_row(8'h10, 4'd2, CHK_PREDICT, '0);
    add_row(8'hE0, 4'd2, CHK_PREDICT, '0);
    add_row(8'hF7, 4'd2, CHK_PREDICT, '0);
    add_row(8'h10, 4'd2, CHK_PREDICT, '0);
    add_row(8'hFF, 4'd3, CHK_PACKET, '{4'd3, mbu_pkg::CIN_SINGLE, 8'hFF, 8'h00, 8'h00});
    add_row(8'h80, 4'd1, CHK_PREDICT, '0);
    add_row(8'h20, 4'd1, CHK_PREDICT, '0);
    add_row(8'hB0, 4'd1, CHK_PREDICT, '0);

    // Synchronous reset, released at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      feed_byte(directed_rows[i].midi, directed_rows[i].cable, directed_rows[i].chk,
                directed_rows[i].pkt);
    end
    wait_drained();

    // Random traffic under three idling mixes. Between mixes the sender
    // pauses until every booked packet has come out; the last mix has no
    // idling and starts with the long receiver hold-off.
    target = bytes_fed;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      if (p == 2) hold_req = 1'b1;
      target = target + PHASE_BYTES;
      while (bytes_fed < target) play_message();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d parsed bytes and %0d bytes on unused cables,", bytes_fed,
             bytes_ignored);
    $display("%0d packets compared, across three idling mixes and a %0d-cycle hold-off",
             packets_seen, HOLD_CYCLES);
    if (mismatches == 0 && usb_packets_due.size() == 0) begin
      $display("tb_midi_byte_to_usb_event_packet_core: clean");
    end else begin
      $display("tb_midi_byte_to_usb_event_packet_core: errors");
    end
    $finish;
  end

endmodule
